@@ hdl/sliding_window_variance_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef SLIDING_WINDOW_VARIANCE_MACROS_SVH
`define SLIDING_WINDOW_VARIANCE_MACROS_SVH

// same-cycle implication
`define SWV_AST_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sliding_window_variance: assertion failed");

// next-cycle implication
`define SWV_AST_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sliding_window_variance: assertion failed");

`endif

@@ hdl/swv_pkg.sv @@
`timescale 1ns / 1ps

package swv_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int CHAN_W       = 2;
	localparam int LEN_W        = 7;
	localparam int VAR_W        = 31;
	localparam int DIGIT_W      = 4;
	localparam int CHANNELS_C   = 4;
	localparam int WINDOW_MAX_C = 64;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_OLD,
		ST_SQO,
		ST_SQX,
		ST_SQS,
		ST_DV1,
		ST_DV2,
		ST_FIN
	} swv_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} swv_unit_st_t;

endpackage

@@ hdl/swv_ifs.sv @@
`timescale 1ns / 1ps

interface swv_in_if;
	import swv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

interface swv_out_if;
	import swv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel_out;
	logic [VAR_W-1:0]  variance;

	modport source (output valid, output channel_out, output variance, input ready);
	modport sink (input valid, input channel_out, input variance, output ready);
endinterface

@@ hdl/swv_sqr.sv @@
`timescale 1ns / 1ps

module swv_sqr #(
	parameter int MAG_W = 22
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [MAG_W-1:0]         operand,
	output logic [2*MAG_W-1:0]       product,
	output swv_pkg::swv_unit_st_t    status
);
	import swv_pkg::*;

	localparam int STEPS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W = STEPS * DIGIT_W;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int PP_W  = MAG_W + DIGIT_W;

	logic [MAG_W-1:0]   a_q;
	logic [PAD_W-1:0]   b_q;
	logic [2*MAG_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PP_W-1:0]    pp;

	// one multiplier digit per cycle, most significant first
	assign pp = PP_W'(a_q) * PP_W'(b_q[PAD_W-1 -: DIGIT_W]);

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= operand;
			b_q   <= PAD_W'(operand);
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << DIGIT_W;
			acc_q <= (acc_q << DIGIT_W) + (2*MAG_W)'(pp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ hdl/swv_div.sv @@
`timescale 1ns / 1ps

module swv_div #(
	parameter int NUM_W = 44
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           dividend,
	input  logic [swv_pkg::LEN_W-1:0]  divisor,
	output logic [NUM_W-1:0]           quotient,
	output swv_pkg::swv_unit_st_t      status
);
	import swv_pkg::*;

	localparam int STEPS = NUM_W / DIGIT_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [NUM_W-1:0] quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_W-1:0] q;
	logic [LEN_W-1:0] r;
	logic [LEN_W:0]   t;

	// restoring division, one quotient digit per cycle; dividend bits shift
	// out of the top while quotient bits shift in at the bottom
	always_comb begin
		q = quo_q;
		r = rem_q;
		t = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, q[NUM_W-1]};
			q = {q[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t    = t - {1'b0, den_q};
				q[0] = 1'b1;
			end
			r = t[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= q;
			rem_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ hdl/sliding_window_variance.sv @@
`timescale 1ns / 1ps
`include "sliding_window_variance_macros.svh"

// Channel   | Dir | Handshake      | Payload
// samples   | in  | valid / ready  | channel (2b), sample (16b signed)
// results   | out | valid / ready  | channel_out (2b), variance (31b)
// cfg       | in  | cfg_we only    | cfg_wdata: window length (7b)
//
// One word at a time: the next word is taken only once the last result has been loaded into
// the output register. Each word goes through a channel lookup, a fetch of the leaving word,
// three passes of the shared 4-bit-digit squarer and two passes of the divider.
// Reset clears control state and per-channel valid bits; the memories are not swept, invalid
// channels read as empty and a fill count gates the delay line.
// A stalled result sits in the output register while the next word is worked on.
module sliding_window_variance #(
	parameter int CHANNELS   = swv_pkg::CHANNELS_C,
	parameter int WINDOW_MAX = swv_pkg::WINDOW_MAX_C
) (
	input  logic                      clk,
	input  logic                      arst_n,
	swv_in_if.sink                    samples,
	swv_out_if.source                 results,
	input  logic                      cfg_we,
	input  logic [swv_pkg::LEN_W-1:0] cfg_wdata
);
	import swv_pkg::*;

	// effective window length never exceeds this
	localparam int LEN_MAX = (1 << LEN_W) - 1;
	localparam int NMAX    = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;

	localparam int SUM_W  = SAMPLE_W + $clog2(NMAX);
	localparam int MAG_W  = SUM_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SQ_W   = 2 * SAMPLE_W - 1 + $clog2(NMAX);
	localparam int DIN_W  = (PROD_W > SQ_W) ? PROD_W : SQ_W;
	localparam int DIV_W  = ((DIN_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int WP_W   = $clog2(WINDOW_MAX);
	localparam int FILL_W = $clog2(NMAX + 1);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DL_AW  = $clog2(CHANNELS * WINDOW_MAX);
	localparam int SL_W   = ((WP_W > LEN_W) ? WP_W : LEN_W) + 1;

	localparam logic [LEN_W-1:0]  NMAX_L = LEN_W'(NMAX);
	localparam logic [FILL_W-1:0] FILL_F = FILL_W'(NMAX);
	localparam logic [DL_AW-1:0]  WM_A   = DL_AW'(WINDOW_MAX);
	localparam logic [WP_W-1:0]   WP_END = WP_W'(WINDOW_MAX - 1);

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
		logic [WP_W-1:0]         wp;
		logic [FILL_W-1:0]       fill;
	} chs_t;

	// ---------------------------------------------------------------- control
	swv_state_t state_q, state_n;

	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    eff_n;
	logic [CHANNELS-1:0] chv_q;
	logic                ovalid_q;
	logic                out_free;
	logic                acc;

	// ------------------------------------------------------------- work regs
	logic [CHAN_W-1:0]          chan_q;
	logic [CH_W-1:0]            ch_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [WP_W-1:0]            wp_q;
	logic [FILL_W-1:0]          fill_q;
	logic                       oldok_q;
	logic [VAR_W-1:0]           res_q;
	logic [CHAN_W-1:0]          ochan_q;
	logic [VAR_W-1:0]           ovar_q;

	// --------------------------------------------------------------- memories
	chs_t                chmem [CHANNELS];
	chs_t                chrd_q;
	logic [SAMPLE_W-1:0] dmem [CHANNELS*WINDOW_MAX];
	logic [SAMPLE_W-1:0] dlrd_q;

	// --------------------------------------------------------------- datapath
	logic [6:0]              chv;
	logic [CH_W-1:0]         ch_mod;
	chs_t                    cur;
	logic [SL_W-1:0]         sl_d;
	logic [WP_W-1:0]         slot;
	logic [DL_AW-1:0]        dl_base;
	logic [DL_AW-1:0]        dl_raddr;
	logic [DL_AW-1:0]        dl_waddr;
	logic signed [SUM_W-1:0] x_ext;
	logic signed [SUM_W-1:0] old_ext;
	logic [MAG_W-1:0]        x_mag;
	logic [MAG_W-1:0]        old_mag;
	logic [MAG_W-1:0]        sum_mag;
	logic [WP_W-1:0]         wp_nx;
	logic [FILL_W-1:0]       fill_nx;
	chs_t                    ch_wdata;
	logic [DIV_W:0]          diff;
	logic [DIV_W-1:0]        diff_pos;

	// unit hookup and sequencer outputs
	logic                 sq_start;
	logic [MAG_W-1:0]     sq_a;
	logic [PROD_W-1:0]    sq_prod;
	swv_unit_st_t         sq_st;
	logic                 dv_start;
	logic [DIV_W-1:0]     dv_num;
	logic [DIV_W-1:0]     dv_quo;
	swv_unit_st_t         dv_st;
	logic                 rdy;
	logic                 ch_we;
	logic                 dl_re;
	logic                 dl_we;
	logic                 out_load;

	assign acc      = samples.valid && rdy;
	assign out_free = !ovalid_q || results.ready;

	// clamp the configured length into 1..NMAX
	always_comb begin
		eff_n = len_q;
		if (len_q == '0) begin
			eff_n = LEN_W'(1);
		end else if (len_q > NMAX_L) begin
			eff_n = NMAX_L;
		end
	end

	// fold the channel number into range; it is only two bits wide
	always_comb begin
		chv = 7'(samples.channel);
		for (int i = 0; i < 3; i++) begin
			if (chv >= 7'(CHANNELS)) begin
				chv = chv - 7'(CHANNELS);
			end
		end
		ch_mod = chv[CH_W-1:0];
	end

	// a channel that has not been written since reset or a length change is empty
	assign cur = chv_q[ch_q] ? chrd_q : '0;

	// slot of the word that leaves the window: wp - n, wrapped
	always_comb begin
		sl_d = SL_W'(cur.wp) - SL_W'(eff_n);
		if (sl_d[SL_W-1]) begin
			sl_d = sl_d + SL_W'(WINDOW_MAX);
		end
		slot = sl_d[WP_W-1:0];
	end

	assign dl_base  = DL_AW'(ch_q) * WM_A;
	assign dl_raddr = dl_base + DL_AW'(slot);
	assign dl_waddr = dl_base + DL_AW'(wp_q);

	assign x_ext   = SUM_W'(x_q);
	assign old_ext = oldok_q ? SUM_W'($signed(dlrd_q)) : '0;
	assign x_mag   = x_ext[SUM_W-1] ? $unsigned(-x_ext) : $unsigned(x_ext);
	assign old_mag = old_ext[SUM_W-1] ? $unsigned(-old_ext) : $unsigned(old_ext);
	assign sum_mag = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

	assign wp_nx   = (wp_q == WP_END) ? '0 : wp_q + 1'b1;
	assign fill_nx = (fill_q == FILL_F) ? fill_q : fill_q + 1'b1;

	assign ch_wdata.sum  = sum_q;
	assign ch_wdata.sq   = sq_q;
	assign ch_wdata.wp   = wp_nx;
	assign ch_wdata.fill = fill_nx;

	// square sum minus normalized square; clamp a borrow to zero
	assign diff     = {1'b0, DIV_W'(sq_q)} - {1'b0, dv_quo};
	assign diff_pos = diff[DIV_W] ? '0 : diff[DIV_W-1:0];

	// ------------------------------------------------------------ next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_n = ST_LOOK;
			end
			ST_LOOK: state_n = ST_OLD;
			ST_OLD:  state_n = ST_SQO;
			ST_SQO: begin
				if (sq_st.done) state_n = ST_SQX;
			end
			ST_SQX: begin
				if (sq_st.done) state_n = ST_SQS;
			end
			ST_SQS: begin
				if (sq_st.done) state_n = ST_DV1;
			end
			ST_DV1: begin
				if (dv_st.done) state_n = ST_DV2;
			end
			ST_DV2: begin
				if (dv_st.done) state_n = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs
	always_comb begin
		rdy      = 1'b0;
		sq_start = 1'b0;
		sq_a     = old_mag;
		dv_start = 1'b0;
		dv_num   = DIV_W'(sq_prod);
		ch_we    = 1'b0;
		dl_re    = 1'b0;
		dl_we    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: rdy = 1'b1;
			// fetch the leaving word
			ST_LOOK: dl_re = 1'b1;
			// store the new word, square the leaving one
			ST_OLD: begin
				dl_we    = 1'b1;
				sq_start = 1'b1;
				sq_a     = old_mag;
			end
			ST_SQO: begin
				sq_start = sq_st.done;
				sq_a     = x_mag;
			end
			ST_SQX: begin
				sq_start = sq_st.done;
				sq_a     = sum_mag;
			end
			// sums are final here: write the channel back, divide the square
			ST_SQS: begin
				ch_we    = sq_st.done;
				dv_start = sq_st.done;
				dv_num   = DIV_W'(sq_prod);
			end
			ST_DV1: begin
				dv_start = dv_st.done;
				dv_num   = diff_pos;
			end
			ST_DV2: ;
			ST_FIN:  out_load = out_free;
			default: ;
		endcase
	end

	assign samples.ready = rdy;

	// --------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= LEN_RESET;
			chv_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			// a length change empties every channel; it wins over a write-back
			if (cfg_we) begin
				chv_q <= '0;
			end else if (ch_we) begin
				chv_q[ch_q] <= 1'b1;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------ work regs
	always_ff @(posedge clk) begin
		if (acc) begin
			chan_q <= samples.channel;
			ch_q   <= ch_mod;
			x_q    <= samples.sample;
		end
		if (state_q == ST_LOOK) begin
			sum_q   <= cur.sum;
			sq_q    <= cur.sq;
			wp_q    <= cur.wp;
			fill_q  <= cur.fill;
			oldok_q <= (LEN_W'(cur.fill) >= eff_n);
		end
		// drop the leaving word and add the new one
		if (state_q == ST_OLD) begin
			sum_q <= sum_q + x_ext - old_ext;
		end
		if (state_q == ST_SQO && sq_st.done) begin
			sq_q <= sq_q - sq_prod[SQ_W-1:0];
		end
		if (state_q == ST_SQX && sq_st.done) begin
			sq_q <= sq_q + sq_prod[SQ_W-1:0];
		end
		if (state_q == ST_DV2 && dv_st.done) begin
			res_q <= dv_quo[VAR_W-1:0];
		end
		if (out_load) begin
			ochan_q <= chan_q;
			ovar_q  <= res_q;
		end
	end

	// -------------------------------------------------------------- memories
	always_ff @(posedge clk) begin
		if (acc) begin
			chrd_q <= chmem[ch_mod];
		end
		if (ch_we) begin
			chmem[ch_q] <= ch_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dl_re) begin
			dlrd_q <= dmem[dl_raddr];
		end
		if (dl_we) begin
			dmem[dl_waddr] <= $unsigned(x_q);
		end
	end

	// ----------------------------------------------------------------- units
	swv_sqr #(
		.MAG_W(MAG_W)
	) u_sqr (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_a),
		.product (sq_prod),
		.status  (sq_st)
	);

	swv_div #(
		.NUM_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_num),
		.divisor  (eff_n),
		.quotient (dv_quo),
		.status   (dv_st)
	);

	assign results.valid       = ovalid_q;
	assign results.channel_out = ochan_q;
	assign results.variance    = ovar_q;

	// ------------------------------------------------------------ assertions
	`SWV_AST_IMPL(a_units_excl, clk, arst_n, sq_st.busy, !dv_st.busy)
	`SWV_AST_NEXT(a_accept_look, clk, arst_n, acc, state_q == ST_LOOK)
	`SWV_AST_NEXT(a_cfg_empties, clk, arst_n, cfg_we, chv_q == '0)
	`SWV_AST_NEXT(a_result_shown, clk, arst_n, out_load, results.valid && state_q == ST_IDLE)

endmodule

@@ test/sliding_window_variance_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_variance_tb;
	import swv_pkg::*;

	// Settle time before a register write: a little more than one word's latency.
	localparam int SETTLE_CYCLES = 60;
	// Long receiver hold-off, enough for the block to fill and stall its input.
	localparam int HOLD_CYCLES = 400;
	// Table marker for rows that leave the window length alone.
	localparam int KEEP_LEN = -1;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 116;

	typedef struct {
		int                         new_len;
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] smp;
		bit                         fixed;
		logic [VAR_W-1:0]           fixed_variance;
	} stim_row_t;

	typedef struct {
		logic [CHAN_W-1:0] chan;
		logic [VAR_W-1:0]  variance;
	} variance_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	swv_in_if  samples_if ();
	swv_out_if results_if ();

	sliding_window_variance i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Mirror of the block: one delay line, sum and square sum per channel.
	logic signed [SAMPLE_W-1:0] win_line [CHANNELS_C][WINDOW_MAX_C];
	longint                     win_sum [CHANNELS_C];
	longint                     win_sq_sum [CHANNELS_C];
	int                         win_pos [CHANNELS_C];
	logic [LEN_W-1:0]           win_len;

	// Variances still owed by the block, oldest first.
	variance_word_t pending_variances [$];

	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int length_writes = 0;
	longint peak_variance = 0;
	bit calm = 1'b0;          // no idling on either side
	int hold_requests = 0;    // bumped by the stimulus, served by the receiver

	// Clear every window, as reset and any length write do.
	function automatic void clear_windows(logic [LEN_W-1:0] len);
		win_len = len;
		for (int c = 0; c < CHANNELS_C; c++) begin
			win_sum[c] = 0;
			win_sq_sum[c] = 0;
			win_pos[c] = 0;
			for (int s = 0; s < WINDOW_MAX_C; s++)
				win_line[c][s] = '0;
		end
	endfunction

	// Slide one channel's window by a sample and return its new variance.
	function automatic logic [VAR_W-1:0] advance_window(logic [CHAN_W-1:0] chan,
			logic signed [SAMPLE_W-1:0] smp);
		int     c;
		int     n;
		int     pos;
		int     old_slot;
		longint x;
		longint old;
		longint norm;
		longint result;
		c = int'(chan) % CHANNELS_C;
		n = int'(win_len);
		// zero acts as one, anything past the delay line depth saturates
		if (n < 1)
			n = 1;
		if (n > WINDOW_MAX_C)
			n = WINDOW_MAX_C;
		pos = win_pos[c];
		old_slot = (pos + WINDOW_MAX_C - n) % WINDOW_MAX_C;
		x = longint'(smp);
		old = longint'(win_line[c][old_slot]);
		win_line[c][pos] = smp;
		win_pos[c] = (pos + 1) % WINDOW_MAX_C;
		win_sum[c] = win_sum[c] + x - old;
		win_sq_sum[c] = win_sq_sum[c] + x * x - old * old;
		norm = (win_sum[c] * win_sum[c]) / n;
		result = (win_sq_sum[c] >= norm) ? (win_sq_sum[c] - norm) / n : 0;
		if (result > peak_variance)
			peak_variance = result;
		return result[VAR_W-1:0];
	endfunction

	// Full-range noise half the time, with the rails, zero and small values mixed in.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return SAMPLE_W'($urandom_range(16) - 8);
			4: return SAMPLE_W'($urandom_range(2000) - 1000);
			default: return SAMPLE_W'($urandom_range(65535));
		endcase
	endfunction

	// Offer one word, hold it until taken, then log what the block owes for it.
	task automatic push_sample(logic [CHAN_W-1:0] chan, logic signed [SAMPLE_W-1:0] smp,
			bit fixed, logic [VAR_W-1:0] fixed_variance);
		variance_word_t owed;
		while (!calm && $urandom_range(99) < 38) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid   <= 1'b1;
		samples_if.channel <= chan;
		samples_if.sample  <= smp;
		do
			@(posedge clk);
		while (!samples_if.ready);
		owed.chan = chan;
		owed.variance = advance_window(chan, smp);
		// hand-typed rows override the mirror, which still has to advance
		if (fixed)
			owed.variance = fixed_variance;
		pending_variances.push_back(owed);
		words_sent++;
	endtask

	// Stop offering and wait until every owed variance is back.
	task automatic drain_results();
		samples_if.valid <= 1'b0;
		while (pending_variances.size() != 0)
			@(posedge clk);
	endtask

	// Write the window length once the block is idle; the write clears all windows.
	task automatic write_window_length(logic [LEN_W-1:0] len);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		clear_windows(len);
		length_writes++;
	endtask

	// Directed words: rails, alternating bit patterns, and the length corner
	// cases (one, zero read as one, two, saturated above the depth, full depth).
	// Rows with a fixed variance hold values obvious from the formula: a first
	// zero sample gives zero, and a window of one sample always gives zero.
	stim_row_t directed_rows [21] = '{
		'{KEEP_LEN, 2'd0, 16'sh0000, 1'b1, 31'd0},
		'{KEEP_LEN, 2'd1, 16'sh7FFF, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd1, 16'sh8000, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd2, 16'sh8000, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd3, 16'shFFFF, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd3, 16'sh0001, 1'b0, 31'd0},
		'{1,        2'd0, 16'sh7FFF, 1'b1, 31'd0},
		'{KEEP_LEN, 2'd0, 16'sh8000, 1'b1, 31'd0},
		'{KEEP_LEN, 2'd2, 16'sh3039, 1'b1, 31'd0},
		'{0,        2'd1, 16'sh8000, 1'b1, 31'd0},
		'{KEEP_LEN, 2'd1, 16'sh7FFF, 1'b1, 31'd0},
		'{2,        2'd0, 16'sh7FFF, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd0, 16'sh8000, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd0, 16'sh7FFF, 1'b0, 31'd0},
		'{127,      2'd2, 16'sh8000, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd2, 16'sh7FFF, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd3, 16'shAAAA, 1'b0, 31'd0},
		'{64,       2'd1, 16'sh5555, 1'b0, 31'd0},
		'{KEEP_LEN, 2'd1, 16'shAAAA, 1'b0, 31'd0},
		'{16,       2'd0, 16'sh0000, 1'b1, 31'd0},
		'{KEEP_LEN, 2'd3, 16'sh0064, 1'b0, 31'd0}
	};

	// Window lengths of the random phases; the last one is drawn at run time.
	int phase_lengths [PHASES] = '{2, 64, 127, 1, 0, 5, 37, 16};

	// Receiver: random stalls, a calm stretch, and the long hold-off on request.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else if (holds_served < hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= calm || ($urandom_range(99) >= 38);
			end
		end
	end

	// Check each variance word against the oldest owed one.
	always @(posedge clk) begin
		variance_word_t owed;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_variances.size() == 0) begin
				$error("unexpected word: channel_out %0d variance %0d",
					results_if.channel_out, results_if.variance);
				errors++;
			end else begin
				owed = pending_variances.pop_front();
				words_checked++;
				if (results_if.channel_out !== owed.chan) begin
					$error("channel_out: expected %0d, got %0d",
						owed.chan, results_if.channel_out);
					errors++;
				end
				if (results_if.variance !== owed.variance) begin
					$error("variance: expected %0d, got %0d",
						owed.variance, results_if.variance);
					errors++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, then random phases, one length each.
	initial begin
		logic [CHAN_W-1:0] chan;
		int len;
		samples_if.valid   <= 1'b0;
		samples_if.channel <= '0;
		samples_if.sample  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		clear_windows(LEN_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].new_len != KEEP_LEN)
				write_window_length(LEN_W'(directed_rows[r].new_len));
			push_sample(directed_rows[r].chan, directed_rows[r].smp,
				directed_rows[r].fixed, directed_rows[r].fixed_variance);
		end

		chan = '0;
		for (int p = 0; p < PHASES; p++) begin
			len = (p == PHASES - 1) ? $urandom_range(3, 63) : phase_lengths[p];
			write_window_length(LEN_W'(len));
			// phase two runs with no idling at all; phase three starts with the
			// long receiver hold-off while words keep coming
			calm = (p == 2);
			if (p == 3)
				hold_requests++;
			for (int w = 0; w < PHASE_WORDS; w++) begin
				// runs on one channel fill its window faster
				if ($urandom_range(9) >= 3)
					chan = CHAN_W'($urandom_range(CHANNELS_C - 1));
				push_sample(chan, pick_sample(), 1'b0, '0);
			end
			calm = 1'b0;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d sample words over %0d window length settings",
			words_sent, length_writes + 1);
		$display("checked %0d variance words, largest variance %0d",
			words_checked, peak_variance);
		if (errors == 0) begin
			$display("sliding_window_variance_tb: PASS");
		end else begin
			$display("sliding_window_variance_tb: FAIL");
		end
		$finish;
	end

	// Watchdog: a correct run needs roughly a tenth of this.
	initial begin
		#5ms;
		$display("sliding_window_variance_tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/swv_pkg.sv
hdl/swv_ifs.sv
hdl/swv_sqr.sv
hdl/swv_div.sv
hdl/sliding_window_variance.sv
test/sliding_window_variance_tb.sv
